/* rtl/pcwd_pkg.sv */
package pcwd_pkg;

   // Width of every field on the request, response and control ports.
   localparam int XW        = 32;
   localparam int MODE_W    = 4;
   localparam int CSR_DW    = 2 * XW;
   localparam int CSR_AW    = 3;

   // Queue depths: the front queue, and the response queue behind the back end.
   localparam int MID_DEPTH = 8;
   localparam int OUT_DEPTH = 8;

   // Bit positions in the mode register.
   localparam int MODE_LIMIT = 0;
   localparam int MODE_DAMP  = 1;
   localparam int MODE_WRAP  = 2;
   localparam int MODE_DEAD  = 3;

   typedef enum logic [CSR_AW-1:0] {
      CSR_KP        = 3'd0,
      CSR_KI_DT     = 3'd1,
      CSR_KD_PER_DT = 3'd2,
      CSR_MODE      = 3'd3,
      CSR_LIMITS    = 3'd4,
      CSR_DAMP      = 3'd5,
      CSR_WRAP      = 3'd6,
      CSR_DEAD      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [XW-1:0] kp;
      logic signed [XW-1:0] ki_dt;
      logic signed [XW-1:0] kd_per_dt;
      logic [MODE_W-1:0]    mode;
      logic signed [XW-1:0] lim_lo;
      logic signed [XW-1:0] lim_hi;
      logic signed [XW-1:0] damp_lo;
      logic signed [XW-1:0] damp_hi;
      logic signed [XW-1:0] wrap_lo;
      logic signed [XW-1:0] wrap_hi;
      logic signed [XW-1:0] dead_lo;
      logic signed [XW-1:0] dead_hi;
   } cfg_type;

endpackage

/* rtl/pid_controller_wrap_deadzone_unit.sv */
// Fixed-point PID controller with error rollover, damping band, output limits
// and dead zone; one drive value is produced for each request.
// Request side: present setpoint and measured with req_push high; the request
// is taken at a clock edge where req_full is low. Response side: while
// rsp_empty is low, rsp_drive holds the oldest drive; it is taken at a clock
// edge where rsp_pop is high. Control registers are written through csr_wen,
// csr_index and csr_wdata, one register per edge; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Throughput is one request per cycle while req_full stays low: the front end
// forms the error and the integral in two stages, and the back end multiplies,
// sums and limits in four stages.
// Each side reserves space in the queue after it, so a response side that
// stops popping fills the response queue, then the front queue, and req_full
// rises; no request is lost. Up to eight requests wait on each side.
// Reset clears the gains, modes, bounds, integral and previous error to zero
// and empties both queues; it takes effect at the next clock edge.
module pid_controller_wrap_deadzone_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [pcwd_pkg::XW-1:0]      req_setpoint,
   input  logic signed [pcwd_pkg::XW-1:0]      req_measured,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [pcwd_pkg::XW-1:0]      rsp_drive,
   input  logic                                csr_wen,
   input  logic [pcwd_pkg::CSR_AW-1:0]         csr_index,
   input  logic [pcwd_pkg::CSR_DW-1:0]         csr_wdata
);

   localparam int XW = pcwd_pkg::XW;
   localparam int DW = DATA_WIDTH;
   localparam int AW = ACC_WIDTH;
   localparam int MW = 2 * DW + AW + 1;

   pcwd_pkg::cfg_type cfg_ff, cfg_in;

   logic                  f_push;
   logic signed [DW-1:0]  f_err;
   logic signed [AW-1:0]  f_integ;
   logic signed [DW:0]    f_diff;
   logic [MW-1:0]         mid_wdata, mid_rdata;
   logic                  mid_empty, mid_pop;
   logic                  out_push, out_pop;
   logic [XW-1:0]         out_drive, out_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      unique case (pcwd_pkg::csr_index_type'(csr_index))
         pcwd_pkg::CSR_KP:        cfg_in.kp        = csr_wdata[XW-1:0];
         pcwd_pkg::CSR_KI_DT:     cfg_in.ki_dt     = csr_wdata[XW-1:0];
         pcwd_pkg::CSR_KD_PER_DT: cfg_in.kd_per_dt = csr_wdata[XW-1:0];
         pcwd_pkg::CSR_MODE:      cfg_in.mode      = csr_wdata[pcwd_pkg::MODE_W-1:0];
         pcwd_pkg::CSR_LIMITS: begin
            cfg_in.lim_lo = csr_wdata[XW-1:0];
            cfg_in.lim_hi = csr_wdata[2*XW-1:XW];
         end
         pcwd_pkg::CSR_DAMP: begin
            cfg_in.damp_lo = csr_wdata[XW-1:0];
            cfg_in.damp_hi = csr_wdata[2*XW-1:XW];
         end
         pcwd_pkg::CSR_WRAP: begin
            cfg_in.wrap_lo = csr_wdata[XW-1:0];
            cfg_in.wrap_hi = csr_wdata[2*XW-1:XW];
         end
         pcwd_pkg::CSR_DEAD: begin
            cfg_in.dead_lo = csr_wdata[XW-1:0];
            cfg_in.dead_hi = csr_wdata[2*XW-1:XW];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wen) begin
         cfg_ff <= cfg_in;
      end
   end

   pcwd_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .ACC_WIDTH  (ACC_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .mid_push     (f_push),
      .mid_err      (f_err),
      .mid_integ    (f_integ),
      .mid_diff     (f_diff),
      .mid_pop      (mid_pop)
   );

   assign mid_wdata = {f_err, f_integ, f_diff};

   pcwd_queue #(
      .WIDTH (MW),
      .DEPTH (pcwd_pkg::MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (mid_wdata),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   pcwd_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .ACC_WIDTH  (ACC_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_err   (mid_rdata[MW-1:DW+AW+1]),
      .mid_integ (mid_rdata[DW+AW:DW+1]),
      .mid_diff  (mid_rdata[DW:0]),
      .out_push  (out_push),
      .out_drive (out_drive),
      .out_pop   (out_pop)
   );

   assign out_pop = rsp_pop & ~rsp_empty;

   pcwd_queue #(
      .WIDTH (XW),
      .DEPTH (pcwd_pkg::OUT_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_drive),
      .pop   (out_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_drive = out_rdata;

endmodule

/* rtl/pcwd_queue.sv */
module pcwd_queue #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int PTR_W = IDX_W + 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff[IDX_W-1:0]] <= wdata;
      end
   end

   assign rdata = slot_ff[rd_ptr_ff[IDX_W-1:0]];
   assign empty = (wr_ptr_ff == rd_ptr_ff);

`ifndef NO_ASSERTIONS
   // The credit counters upstream must keep the queue from ever overflowing.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ((wr_ptr_ff - rd_ptr_ff) != PTR_W'(DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
`endif

endmodule

/* rtl/pcwd_front.sv */
module pcwd_front #(
   parameter int DATA_WIDTH = 32,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pcwd_pkg::cfg_type                  cfg,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [pcwd_pkg::XW-1:0]     req_setpoint,
   input  logic signed [pcwd_pkg::XW-1:0]     req_measured,
   output logic                               mid_push,
   output logic signed [DATA_WIDTH-1:0]       mid_err,
   output logic signed [ACC_WIDTH-1:0]        mid_integ,
   output logic signed [DATA_WIDTH:0]         mid_diff,
   input  logic                               mid_pop
);

   localparam int XW    = pcwd_pkg::XW;
   localparam int DW    = DATA_WIDTH;
   localparam int AW    = ACC_WIDTH;
   localparam int EW    = XW + 2;
   localparam int SW    = (DW > EW) ? DW : EW;
   localparam int CW    = (DW > XW) ? DW : XW;
   localparam int IW    = ((AW > DW) ? AW : DW) + 1;
   localparam int CNT_W = $clog2(pcwd_pkg::MID_DEPTH + 1);

   localparam logic signed [SW-1:0] E_MAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [SW-1:0] E_MIN = ~E_MAX;
   localparam logic signed [IW-1:0] A_MAX = {{(IW-AW+1){1'b0}}, {(AW-1){1'b1}}};
   localparam logic signed [IW-1:0] A_MIN = ~A_MAX;

   // Requests accepted and not yet taken from the front queue by the back end.
   logic [CNT_W-1:0] credit_ff, credit_in;
   logic             accept;

   logic             s1_valid_ff;
   logic [XW:0]      s1_err_ff, s1_err_in;
   logic             s2_valid_ff;
   logic signed [DW-1:0] s2_err_ff, s2_err_in;

   logic signed [AW-1:0] integ_ff, integ_in;
   logic signed [DW-1:0] prev_ff, prev_in;

   // Rollover stage.
   logic [XW:0]          mag;
   logic signed [XW:0]   span;
   logic                 wrap_hit;
   logic                 err_pos;
   logic [EW-1:0]        err_ext, rhi_ext, err_wrap, err_sel;
   logic signed [SW-1:0] err_wide;

   // Integral stage.
   logic signed [CW-1:0] err_cw, dlo_cw, dhi_cw;
   logic                 damp_hit;
   logic signed [DW-1:0] err_c;
   logic signed [AW-1:0] integ_base;
   logic signed [IW-1:0] integ_sum;
   logic signed [AW-1:0] integ_sat;

   assign req_full = (credit_ff == CNT_W'(pcwd_pkg::MID_DEPTH));
   assign accept   = req_push & ~req_full;

   always_comb begin
      unique case ({accept, mid_pop})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   assign s1_err_in = {req_setpoint[XW-1], req_setpoint} - {req_measured[XW-1], req_measured};

   always_comb begin
      mag      = s1_err_ff[XW] ? (~s1_err_ff + 1'b1) : s1_err_ff;
      span     = {cfg.wrap_hi[XW-1], cfg.wrap_hi} - {cfg.wrap_lo[XW-1], cfg.wrap_lo};
      // A negative span is below any doubled magnitude.
      wrap_hit = span[XW] | ({mag, 1'b0} > {1'b0, span});
      err_pos  = ~s1_err_ff[XW] & (|s1_err_ff);
      err_ext  = {s1_err_ff[XW], s1_err_ff};
      rhi_ext  = {{2{cfg.wrap_hi[XW-1]}}, cfg.wrap_hi};
      err_wrap = err_pos ? err_ext - rhi_ext : err_ext + rhi_ext;
      err_sel  = (cfg.mode[pcwd_pkg::MODE_WRAP] && wrap_hit) ? err_wrap : err_ext;
      err_wide = SW'($signed(err_sel));
      priority if (err_wide > E_MAX) begin
         s2_err_in = E_MAX[DW-1:0];
      end else if (err_wide < E_MIN) begin
         s2_err_in = E_MIN[DW-1:0];
      end else begin
         s2_err_in = err_wide[DW-1:0];
      end
   end

   always_comb begin
      err_cw     = CW'(s2_err_ff);
      dlo_cw     = CW'(cfg.damp_lo);
      dhi_cw     = CW'(cfg.damp_hi);
      damp_hit   = cfg.mode[pcwd_pkg::MODE_DAMP] && (err_cw < dhi_cw) && (err_cw > dlo_cw);
      err_c      = damp_hit ? '0 : s2_err_ff;
      integ_base = damp_hit ? (integ_ff >>> 1) : integ_ff;
      integ_sum  = IW'(integ_base) + IW'(err_c);
      priority if (integ_sum > A_MAX) begin
         integ_sat = A_MAX[AW-1:0];
      end else if (integ_sum < A_MIN) begin
         integ_sat = A_MIN[AW-1:0];
      end else begin
         integ_sat = integ_sum[AW-1:0];
      end
      integ_in = s2_valid_ff ? integ_sat : integ_ff;
      prev_in  = s2_valid_ff ? err_c : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         integ_ff    <= '0;
         prev_ff     <= '0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         integ_ff    <= integ_in;
         prev_ff     <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_err_ff <= s1_err_in;
      s2_err_ff <= s2_err_in;
   end

   assign mid_push  = s2_valid_ff;
   assign mid_err   = err_c;
   assign mid_integ = integ_sat;
   assign mid_diff  = (DW+1)'(err_c) - (DW+1)'(prev_ff);

`ifndef NO_ASSERTIONS
   // A request inside the pipeline must still hold its credit.
   a_front_credit: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |-> (credit_ff != '0))
      else $error("front pipeline holds a request without credit");
`endif

endmodule

/* rtl/pcwd_back.sv */
module pcwd_back #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pcwd_pkg::cfg_type              cfg,
   input  logic                           mid_empty,
   output logic                           mid_pop,
   input  logic signed [DATA_WIDTH-1:0]   mid_err,
   input  logic signed [ACC_WIDTH-1:0]    mid_integ,
   input  logic signed [DATA_WIDTH:0]     mid_diff,
   output logic                           out_push,
   output logic [pcwd_pkg::XW-1:0]        out_drive,
   input  logic                           out_pop
);

   localparam int XW    = pcwd_pkg::XW;
   localparam int DW    = DATA_WIDTH;
   localparam int FB    = FRAC_BITS;
   localparam int AW    = ACC_WIDTH;
   localparam int IL    = AW / 2;
   localparam int IH    = AW - IL;
   localparam int CW    = (DW > XW) ? DW : XW;
   localparam int PW    = (((AW > DW + 1) ? AW : DW + 1) + XW) + 2;
   localparam int TW    = PW - FB - DW + 1;
   localparam int CNT_W = $clog2(pcwd_pkg::OUT_DEPTH + 1);

   localparam logic [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

   // Requests taken from the front queue and not yet popped as responses.
   logic [CNT_W-1:0] credit_ff, credit_in;

   logic                     b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic [1:0]               b1_sign_ff, b2_sign_ff, b3_sign_ff, b4_sign_ff;
   logic [1:0]               b1_sign_in;
   logic signed [XW+DW-1:0]  pk_ff, pk_in;
   logic signed [XW+DW:0]    pd_ff, pd_in;
   logic signed [XW+IL:0]    pil_ff, pil_in;
   logic signed [XW+IH-1:0]  pih_ff, pih_in;
   logic signed [PW-1:0]     pi_ff, pi_in;
   logic signed [PW-1:0]     pkd_ff, pkd_in;
   logic signed [PW-1:0]     acc;
   logic [TW-1:0]            acc_top;
   logic [DW-1:0]            drive_sat;
   logic signed [CW-1:0]     b3_drive_ff, b3_drive_in;
   logic signed [CW-1:0]     lo_cw, hi_cw, d_upper;
   logic signed [CW-1:0]     b4_drive_ff, b4_drive_in;
   logic signed [CW-1:0]     dlo_cw, dhi_cw, drive_final;

   assign mid_pop = ~mid_empty & (credit_ff != CNT_W'(pcwd_pkg::OUT_DEPTH));

   always_comb begin
      unique case ({mid_pop, out_pop})
         2'b10:   credit_in = credit_ff + 1'b1;
         2'b01:   credit_in = credit_ff - 1'b1;
         default: credit_in = credit_ff;
      endcase
   end

   // Sign flags of the error: bit 1 positive, bit 0 negative.
   assign b1_sign_in = {~mid_err[DW-1] & (|mid_err), mid_err[DW-1]};

   // The integral product is split into two narrower partial products.
   always_comb begin
      pk_in  = cfg.kp * mid_err;
      pd_in  = cfg.kd_per_dt * mid_diff;
      pil_in = cfg.ki_dt * $signed({1'b0, mid_integ[IL-1:0]});
      pih_in = cfg.ki_dt * $signed(mid_integ[AW-1:IL]);
   end

   always_comb begin
      pi_in  = PW'(pil_ff) + (PW'(pih_ff) <<< IL);
      pkd_in = PW'(pk_ff) + PW'(pd_ff);
   end

   // Sum, drop the fraction rounding toward minus infinity, then saturate.
   always_comb begin
      acc     = pi_ff + pkd_ff;
      acc_top = acc[PW-1:FB+DW-1];
      if ((&acc_top) || !(|acc_top)) begin
         drive_sat = acc[FB+DW-1:FB];
      end else begin
         drive_sat = acc[PW-1] ? D_MIN : D_MAX;
      end
      b3_drive_in = CW'($signed(drive_sat));
   end

   // The upper limit is applied first, so a crossed pair gives the lower bound.
   always_comb begin
      lo_cw   = CW'(cfg.lim_lo);
      hi_cw   = CW'(cfg.lim_hi);
      d_upper = (cfg.mode[pcwd_pkg::MODE_LIMIT] && (b3_drive_ff > hi_cw)) ? hi_cw : b3_drive_ff;
      b4_drive_in = (cfg.mode[pcwd_pkg::MODE_LIMIT] && (d_upper < lo_cw)) ? lo_cw : d_upper;
   end

   always_comb begin
      dlo_cw = CW'(cfg.dead_lo);
      dhi_cw = CW'(cfg.dead_hi);
      if (cfg.mode[pcwd_pkg::MODE_DEAD] && (|b4_sign_ff) &&
          (b4_drive_ff < dhi_cw) && (b4_drive_ff > dlo_cw)) begin
         drive_final = b4_sign_ff[1] ? dhi_cw : dlo_cw;
      end else begin
         drive_final = b4_drive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         b1_valid_ff <= mid_pop;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_sign_ff  <= b1_sign_in;
      b2_sign_ff  <= b1_sign_ff;
      b3_sign_ff  <= b2_sign_ff;
      b4_sign_ff  <= b3_sign_ff;
      pk_ff       <= pk_in;
      pd_ff       <= pd_in;
      pil_ff      <= pil_in;
      pih_ff      <= pih_in;
      pi_ff       <= pi_in;
      pkd_ff      <= pkd_in;
      b3_drive_ff <= b3_drive_in;
      b4_drive_ff <= b4_drive_in;
   end

   assign out_push  = b4_valid_ff;
   assign out_drive = drive_final[XW-1:0];

`ifndef NO_ASSERTIONS
   // Every request in the back pipeline has reserved a response slot.
   a_back_credit: assert property (@(posedge clock) disable iff (reset)
      (b1_valid_ff || b2_valid_ff || b3_valid_ff || b4_valid_ff) |-> (credit_ff != '0))
      else $error("back pipeline holds a request without a response slot");

   a_back_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(pcwd_pkg::OUT_DEPTH))
      else $error("response credit above queue depth");
`endif

endmodule

/* tb/sv/testbench.sv */
module testbench;
   import pcwd_pkg::*;

   localparam int     FRAC       = 16;
   localparam longint ACC_MAX    = 64'sh7FFF_FFFF_FFFF;
   localparam longint DRIVE_MAX  = 64'sh7FFF_FFFF;
   localparam longint DRIVE_MIN  = -DRIVE_MAX - 1;
   localparam int     IDLE_LIMIT = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic signed [XW-1:0]  req_setpoint = '0;
   logic signed [XW-1:0]  req_measured = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic signed [XW-1:0]  rsp_drive;
   logic                  csr_wen = 1'b0;
   logic [CSR_AW-1:0]     csr_index = '0;
   logic [CSR_DW-1:0]     csr_wdata = '0;

   bit steady = 1'b0;
   int idle_cycles = 0;

   pid_controller_wrap_deadzone_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_drive    (rsp_drive),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   class pid_scoreboard;
      longint            kp_gain, ki_gain, kd_gain;
      logic [MODE_W-1:0] modes;
      logic [63:0]       limits, damp, wrap, dead;
      longint            integral, prev_err;
      logic [XW-1:0]     pending_drives[$];
      int                errors;

      function new();
         kp_gain = 0; ki_gain = 0; kd_gain = 0;
         modes = '0; limits = '0; damp = '0; wrap = '0; dead = '0;
         integral = 0; prev_err = 0; errors = 0;
      endfunction

      function longint lo_of(logic [63:0] p);
         return longint'($signed(p[31:0]));
      endfunction

      function longint hi_of(logic [63:0] p);
         return longint'($signed(p[63:32]));
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DW-1:0] d);
         case (idx)
            CSR_KP:        kp_gain = longint'($signed(d[31:0]));
            CSR_KI_DT:     ki_gain = longint'($signed(d[31:0]));
            CSR_KD_PER_DT: kd_gain = longint'($signed(d[31:0]));
            CSR_MODE:      modes = d[MODE_W-1:0];
            CSR_LIMITS:    limits = d;
            CSR_DAMP:      damp = d;
            CSR_WRAP:      wrap = d;
            CSR_DEAD:      dead = d;
            default: ;
         endcase
      endfunction

      function void note_request(logic signed [XW-1:0] sp, logic signed [XW-1:0] ms);
         longint err, mag, drv;
         logic signed [127:0] acc, fa, fb;
         err = longint'(sp) - longint'(ms);
         if (modes[MODE_WRAP]) begin
            mag = (err < 0) ? -err : err;
            if (2 * mag > hi_of(wrap) - lo_of(wrap))
               err = (err > 0) ? err - hi_of(wrap) : err + hi_of(wrap);
         end
         if (err > DRIVE_MAX) err = DRIVE_MAX;
         else if (err < DRIVE_MIN) err = DRIVE_MIN;
         if (modes[MODE_DAMP] && err < hi_of(damp) && err > lo_of(damp)) begin
            integral = integral >>> 1;
            err = 0;
         end
         if (err > 0 && integral > ACC_MAX - err) integral = ACC_MAX;
         else if (err < 0 && integral < -ACC_MAX - 1 - err) integral = -ACC_MAX - 1;
         else integral += err;
         // The three products are summed at full width before the shift.
         fa = kp_gain; fb = err; acc = fa * fb;
         fa = ki_gain; fb = integral; acc += fa * fb;
         fa = kd_gain; fb = err - prev_err; acc += fa * fb;
         acc = acc >>> FRAC;
         if (acc > DRIVE_MAX) drv = DRIVE_MAX;
         else if (acc < DRIVE_MIN) drv = DRIVE_MIN;
         else drv = longint'(acc);
         prev_err = err;
         if (modes[MODE_LIMIT]) begin
            if (drv > hi_of(limits)) drv = hi_of(limits);
            if (drv < lo_of(limits)) drv = lo_of(limits);
         end
         if (modes[MODE_DEAD] && err != 0 && drv < hi_of(dead) && drv > lo_of(dead))
            drv = (err > 0) ? hi_of(dead) : lo_of(dead);
         pending_drives.push_back(drv[XW-1:0]);
      endfunction

      function void check_drive(logic [XW-1:0] got);
         logic [XW-1:0] want;
         if (pending_drives.size() == 0) begin
            $display("%0t: drive %h arrived, expected none", $time, got);
            errors++;
         end else begin
            want = pending_drives.pop_front();
            if (want !== got) begin
               $display("%0t: drive mismatch, expected %h, got %h", $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   pid_scoreboard sb = new;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_drive(rsp_drive);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_wen) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int run, stall;
      @(posedge clock);
      forever begin
         rsp_pop <= 1'b1;
         run = $urandom_range(1, 20);
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic send(logic signed [XW-1:0] sp, logic signed [XW-1:0] ms);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_setpoint <= sp;
      req_measured <= ms;
      do @(posedge clock); while (req_full);
      sb.note_request(sp, ms);
   endtask

   function logic [XW-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function logic [XW-1:0] rand_gain();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return pick_extreme();
         default: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      endcase
   endfunction

   function logic [63:0] rand_pair();
      logic [31:0] lo, hi;
      case ($urandom_range(0, 3))
         0: begin
            lo = $urandom;
            hi = $urandom;
         end
         1: begin
            lo = $urandom_range(0, 32'h40000);
            hi = 32'h0 - $urandom_range(0, 32'h40000);
         end
         default: begin
            lo = 32'h0 - $urandom_range(0, 32'h40000);
            hi = $urandom_range(0, 32'h40000);
         end
      endcase
      return {hi, lo};
   endfunction

   task automatic send_random();
      logic [XW-1:0] sp, ms;
      logic [63:0] band;
      case ($urandom_range(0, 9))
         0: begin
            sp = $urandom;
            ms = $urandom;
         end
         1: begin
            sp = pick_extreme();
            ms = pick_extreme();
         end
         2, 3, 4, 5: begin
            sp = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
            ms = sp + $urandom_range(0, 1023) - 512;
         end
         6, 7: begin
            sp = $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
            ms = $urandom_range(0, 32'h1FF_FFFF) - 32'h100_0000;
         end
         default: begin
            // Put the error at or within two of a bound of one of the bands.
            case ($urandom_range(0, 3))
               0: band = sb.damp;
               1: band = sb.wrap;
               2: band = sb.dead;
               default: band = sb.limits;
            endcase
            sp = $urandom_range(0, 1) ? band[31:0] : band[63:32];
            sp = sp + $urandom_range(0, 4) - 2;
            ms = 0;
         end
      endcase
      send(sp, ms);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DW-1:0] d);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
   endtask

   task automatic load_setting(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                               logic [3:0] mode, logic [63:0] lim, logic [63:0] damp,
                               logic [63:0] wrap, logic [63:0] dead);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_csr(CSR_KP, {junk[63:32], kp});
      write_csr(CSR_KI_DT, {junk[31:0], ki});
      write_csr(CSR_KD_PER_DT, {junk[47:16], kd});
      write_csr(CSR_MODE, {junk[63:4], mode});
      write_csr(CSR_LIMITS, lim);
      write_csr(CSR_DAMP, damp);
      write_csr(CSR_WRAP, wrap);
      write_csr(CSR_DEAD, dead);
      csr_wen <= 1'b0;
   endtask

   // Registers are only touched once every drive has come back.
   task automatic settle();
      req_push <= 1'b0;
      while (sb.pending_drives.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: all gains zero.
      send(32'h0001_0000, 32'h0000_0000);
      send(32'h7FFF_FFFF, 32'h8000_0000);
      send(32'h8000_0000, 32'h7FFF_FFFF);
      settle();

      load_setting(32'h0001_0000, 32'h0000_0100, 32'h0000_8000, 4'h0, '0, '0, '0, '0);
      send(32'h0000_0000, 32'h0000_0000);
      send(32'h7FFF_FFFF, 32'h8000_0000);
      send(32'h8000_0000, 32'h7FFF_FFFF);
      send(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(32'h8000_0000, 32'h8000_0000);
      send(32'h0000_0001, 32'h0000_0000);
      send(32'h0000_0000, 32'h0000_0001);
      settle();

      // Every mode on: damping band of a few steps, rollover span of 256.0.
      load_setting(32'h0001_0000, 32'h0000_0040, 32'h0000_4000, 4'hF,
                   {32'h0005_0000, 32'hFFFB_0000}, {32'h0000_0008, 32'hFFFF_FFF8},
                   {32'h0100_0000, 32'h0000_0000}, {32'h0000_8000, 32'hFFFF_8000});
      send(32'h0000_0004, 32'h0000_0000);
      send(32'h0000_0008, 32'h0000_0000);
      send(32'hFFFF_FFF8, 32'h0000_0000);
      send(32'h0000_0010, 32'h0000_0000);
      send(32'h0000_0000, 32'h0000_0010);
      send(32'h0000_0000, 32'h0000_0000);
      send(32'h00F0_0000, 32'h0010_0000);
      send(32'h0010_0000, 32'h00F0_0000);
      send(32'h0080_0000, 32'h0000_0000);
      send(32'hFF80_0000, 32'h0000_0000);
      send(32'h7FFF_FFFF, 32'h8000_0000);
      settle();

      // Extreme gains so that the drive saturates; rollover over the whole range.
      load_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 4'h4, '0, '0,
                   {32'h7FFF_FFFF, 32'h8000_0000}, '0);
      send(32'h7FFF_FFFF, 32'h8000_0000);
      send(32'h8000_0000, 32'h7FFF_FFFF);
      send(32'h4000_0000, 32'hC000_0000);
      send(32'h0000_0000, 32'h0000_0000);
      settle();

      // Lower limit above the upper one: the lower limit wins.
      load_setting(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 4'h1,
                   {32'hFFFF_0000, 32'h0001_0000}, '0, '0, '0);
      send(32'h0010_0000, 32'h0000_0000);
      send(32'h0000_0000, 32'h0010_0000);
      settle();

      load_setting('1, '1, '1, 4'hF, '1, '1, '1, '1);
      repeat (60) send_random();
      settle();

      for (int p = 0; p < 8; p++) begin
         steady = ($urandom_range(0, 3) == 0);
         load_setting(rand_gain(), rand_gain(), rand_gain(), 4'($urandom_range(0, 15)),
                      rand_pair(), rand_pair(), rand_pair(), rand_pair());
         repeat (230) send_random();
         settle();
      end

      if (sb.errors == 0 && sb.pending_drives.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
